### rtl/bptb_pkg.sv
// ----------------------------------------------------------------------------
// Branch predicate tracking buffer package
// Shared constants, operation codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package bptb_pkg;

    localparam int TABLE_ENTRIES_DEF   = 16;
    localparam int PREDS_PER_ENTRY_DEF = 4;
    localparam int COMMIT_ROWS_DEF     = 16;

    localparam int IN_TDATA_W  = 112;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_FIELD_W = 75;

    // Request kinds carried on the slave tuser.
    localparam logic [1:0] ACT_ASSIGN = 2'd0;
    localparam logic [1:0] ACT_COMMIT = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_FLUSH  = 2'd3;

    // Datapath operations issued by the controller.
    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_ASSIGN     = 5'd1;
    localparam logic [4:0] OP_COMMIT     = 5'd2;
    localparam logic [4:0] OP_FLUSH      = 5'd3;
    localparam logic [4:0] OP_SCAN       = 5'd4;
    localparam logic [4:0] OP_APPLY      = 5'd5;
    localparam logic [4:0] OP_RES_RD     = 5'd6;
    localparam logic [4:0] OP_RES_LOAD   = 5'd7;
    localparam logic [4:0] OP_U_INIT     = 5'd8;
    localparam logic [4:0] OP_U_ENT_NEXT = 5'd9;
    localparam logic [4:0] OP_U_CNT_LAT  = 5'd10;
    localparam logic [4:0] OP_U_PRED_LAT = 5'd11;
    localparam logic [4:0] OP_U_PRED_NXT = 5'd12;
    localparam logic [4:0] OP_U_ROW_NEXT = 5'd13;
    localparam logic [4:0] OP_U_MATCH    = 5'd14;
    localparam logic [4:0] OP_U_PRED_RD  = 5'd15;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic ent_end;
        logic ent_valid;
        logic pred_end;
        logic row_end;
        logic row_valid;
        logic row_match;
        logic res_last;
        logic out_free;
    } sts_t;

endpackage

### rtl/branch_predicate_tracking_buffer_unit.sv
// Assign request: an accept step, the tag scan over the target memory and an apply step,
//   then 1 to 4 results by default, each handed to a ready sink through the output register.
// Commit and flush requests finish as they are accepted; an update walks every valid
//   entry, each of its stored predicates and the commit rows, writing matched rows back.
// A new request is accepted only once the previous one is finished and the controller is idle.
// Reset (rst_n, asynchronous, active low) empties the table and commit rows.
// ----------------------------------------------------------------------------
// Branch predicate tracking buffer
// Associative buffer keyed by branch target that hands out predicate
// addresses and canceling predicates to instructions as they are assigned.
// ----------------------------------------------------------------------------
module branch_predicate_tracking_buffer_unit #(
    parameter int TABLE_ENTRIES   = bptb_pkg::TABLE_ENTRIES_DEF,
    parameter int PREDS_PER_ENTRY = bptb_pkg::PREDS_PER_ENTRY_DEF,
    parameter int COMMIT_ROWS     = bptb_pkg::COMMIT_ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // From bit 0: is_branch, inst_addr, target_addr, row, commit_paddr,
    // commit_pval, commit_cpaddr, commit_cpval, zero fill.
    input  logic [bptb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // From bit 0: action.
    input  logic [bptb_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // From bit 0: in_paddr, in_pval, cancel_count, cancel_paddr, cancel_pval,
    // out_paddr, out_cpaddr, table_full, zero fill.
    output logic [bptb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);
    import bptb_pkg::*;

    // The controller decodes each request and walks the datapath through the
    // tag scan, the table update and the result sequence. Each result goes
    // through an output register, so the sink may stall at any time.
    cmd_t cmd;
    sts_t sts;

    bptb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .action   (s_axis_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    bptb_dp #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .PREDS_PER_ENTRY (PREDS_PER_ENTRY),
        .COMMIT_ROWS     (COMMIT_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### rtl/bptb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/bptb_ctrl.sv
// ----------------------------------------------------------------------------
// Branch predicate tracking buffer controller
// Sequences assign, commit, update and flush requests over the datapath.
// ----------------------------------------------------------------------------
module bptb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    action,
    input  bptb_pkg::sts_t sts,
    output bptb_pkg::cmd_t cmd,
    output logic          in_ready
);
    import bptb_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_APPLY = 4'd2;
    localparam logic [3:0] S_RRD   = 4'd3;
    localparam logic [3:0] S_RSHOW = 4'd4;
    localparam logic [3:0] S_UE    = 4'd5;
    localparam logic [3:0] S_UC    = 4'd6;
    localparam logic [3:0] S_UP    = 4'd7;
    localparam logic [3:0] S_UA    = 4'd8;
    localparam logic [3:0] S_UR    = 4'd9;
    localparam logic [3:0] S_UM    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (action)
                        ACT_ASSIGN:
                        begin
                            cmd.op     = OP_ASSIGN;
                            state_next = S_SCAN;
                        end
                        ACT_COMMIT: cmd.op = OP_COMMIT;
                        ACT_UPDATE:
                        begin
                            cmd.op     = OP_U_INIT;
                            state_next = S_UE;
                        end
                        default: cmd.op = OP_FLUSH;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (sts.scan_done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.op     = OP_APPLY;
                state_next = S_RRD;
            end
            S_RRD:
            begin
                cmd.op     = OP_RES_RD;
                state_next = S_RSHOW;
            end
            S_RSHOW:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_RES_LOAD;
                    state_next = sts.res_last ? S_IDLE : S_RRD;
                end
                else
                begin
                    // Keep the predicate slot of this result on the read port.
                    cmd.op = OP_RES_RD;
                end
            end
            S_UE:
            begin
                if (sts.ent_end)
                begin
                    state_next = S_IDLE;
                end
                else if (!sts.ent_valid)
                begin
                    cmd.op = OP_U_ENT_NEXT;
                end
                else
                begin
                    state_next = S_UC;
                end
            end
            S_UC:
            begin
                cmd.op     = OP_U_CNT_LAT;
                state_next = S_UP;
            end
            S_UP:
            begin
                if (sts.pred_end)
                begin
                    cmd.op     = OP_U_ENT_NEXT;
                    state_next = S_UE;
                end
                else
                begin
                    cmd.op     = OP_U_PRED_RD;
                    state_next = S_UA;
                end
            end
            S_UA:
            begin
                cmd.op     = OP_U_PRED_LAT;
                state_next = S_UR;
            end
            S_UR:
            begin
                if (sts.row_end)
                begin
                    cmd.op     = OP_U_PRED_NXT;
                    state_next = S_UP;
                end
                else if (!sts.row_valid)
                begin
                    cmd.op = OP_U_ROW_NEXT;
                end
                else
                begin
                    state_next = S_UM;
                end
            end
            S_UM:
            begin
                cmd.op     = OP_U_MATCH;
                state_next = sts.row_match ? S_UP : S_UR;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### rtl/bptb_dp.sv
// ----------------------------------------------------------------------------
// Branch predicate tracking buffer datapath
// Table storage, commit rows, predicate counter and the result register.
// ----------------------------------------------------------------------------
module bptb_dp #(
    parameter int TABLE_ENTRIES   = bptb_pkg::TABLE_ENTRIES_DEF,
    parameter int PREDS_PER_ENTRY = bptb_pkg::PREDS_PER_ENTRY_DEF,
    parameter int COMMIT_ROWS     = bptb_pkg::COMMIT_ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bptb_pkg::cmd_t                   cmd,
    output bptb_pkg::sts_t                   sts,
    input  logic [bptb_pkg::IN_TDATA_W-1:0]  in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bptb_pkg::OUT_TDATA_W-1:0] out_data,
    output logic                             out_last
);
    import bptb_pkg::*;

    localparam int EW1 = $clog2(TABLE_ENTRIES + 1);
    localparam int EAW = $clog2(TABLE_ENTRIES);
    localparam int CAW = $clog2(TABLE_ENTRIES * PREDS_PER_ENTRY);
    localparam int SW  = $clog2(PREDS_PER_ENTRY + 1);
    localparam int RW1 = $clog2(COMMIT_ROWS + 1);
    localparam int RAW = (COMMIT_ROWS > 1) ? $clog2(COMMIT_ROWS) : 1;
    localparam logic [16:0] NONE17 = 17'h1FFFF;
    localparam logic [1:0]  NONE2  = 2'b11;

    // Request fields.
    logic               f_br;
    logic [31:0]        f_inst;
    logic [31:0]        f_tgt;
    logic [3:0]         f_row;
    logic signed [16:0] f_paddr;
    logic signed [1:0]  f_pval;
    logic [16:0]        f_cpaddr;
    logic [1:0]         f_cpval;

    assign f_br     = in_data[0];
    assign f_inst   = in_data[32:1];
    assign f_tgt    = in_data[64:33];
    assign f_row    = in_data[68:65];
    assign f_paddr  = $signed(in_data[85:69]);
    assign f_pval   = $signed(in_data[87:86]);
    assign f_cpaddr = in_data[104:88];
    assign f_cpval  = in_data[106:105];

    // Control state.
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [COMMIT_ROWS-1:0]   rowv_reg, rowv_next;
    logic [15:0]              ctr_reg, ctr_next;
    logic                     delay_reg, delay_next;
    logic signed [16:0]       lat_addr_reg, lat_addr_next;
    logic signed [1:0]        lat_val_reg, lat_val_next;
    logic                     ovalid_reg, ovalid_next;
    logic                     rdv_reg, rdv_next;

    // Working registers.
    logic           br_reg, br_next;
    logic [31:0]    key_reg, key_next;
    logic [31:0]    tgt_reg, tgt_next;
    logic [15:0]    inp_reg, inp_next;
    logic [1:0]     inpv_reg, inpv_next;
    logic           indelay_reg, indelay_next;
    logic [EW1-1:0] ent_reg, ent_next;
    logic [SW-1:0]  sub_reg, sub_next;
    logic [RW1-1:0] row_reg, row_next;
    logic [EAW-1:0] rdidx_reg, rdidx_next;
    logic           kf_reg, kf_next;
    logic [EAW-1:0] kidx_reg, kidx_next;
    logic [SW-1:0]  kcnt_reg, kcnt_next;
    logic           tf_reg, tf_next;
    logic [EAW-1:0] tidx_reg, tidx_next;
    logic [SW-1:0]  tcnt_reg, tcnt_next;
    logic           ff_reg, ff_next;
    logic [EAW-1:0] fidx_reg, fidx_next;
    logic [SW-1:0]  rescnt_reg, rescnt_next;
    logic [16:0]    outp_reg, outp_next;
    logic [16:0]    outcp_reg, outcp_next;
    logic           full_reg, full_next;
    logic [SW-1:0]  updcnt_reg, updcnt_next;
    logic [16:0]    updaddr_reg, updaddr_next;
    logic [OUT_FIELD_W-1:0] od_reg, od_next;
    logic           olast_reg, olast_next;

    // Memory ports.
    logic           tgt_we;
    logic [EAW-1:0] tgt_waddr;
    logic [31:0]    tgt_rdata;
    logic           cnt_we;
    logic [EAW-1:0] cnt_waddr;
    logic [SW-1:0]  cnt_wdata;
    logic [SW-1:0]  cnt_rdata;
    logic           can_we;
    logic [CAW-1:0] can_waddr;
    logic [18:0]    can_wdata;
    logic [CAW-1:0] can_raddr;
    logic [18:0]    can_rdata;
    logic           row_we;
    logic [18:0]    row_rdata;

    logic [EAW-1:0] ent_idx;
    logic [RAW-1:0] row_idx;
    logic [15:0]    inp_w;
    logic           last_w;

    function automatic logic [CAW-1:0] slot(input logic [EAW-1:0] idx,
                                            input logic [SW-1:0] sub);
        slot = CAW'(int'(idx) * PREDS_PER_ENTRY + int'(sub));
    endfunction

    assign ent_idx   = ent_reg[EAW-1:0];
    assign row_idx   = row_reg[RAW-1:0];
    assign can_raddr = (cmd.op == OP_RES_RD) ? slot(kidx_reg, sub_reg)
                                             : slot(ent_idx, sub_reg);
    assign inp_w     = ctr_reg + 16'(delay_reg & f_br);
    assign last_w    = (rescnt_reg == '0) ||
                       ({1'b0, sub_reg} + (SW+1)'(1) == {1'b0, rescnt_reg});

    assign sts.scan_done = (ent_reg == EW1'(TABLE_ENTRIES)) && !rdv_reg;
    assign sts.ent_end   = (ent_reg == EW1'(TABLE_ENTRIES));
    assign sts.ent_valid = valid_reg[ent_idx];
    assign sts.pred_end  = (sub_reg == updcnt_reg);
    assign sts.row_end   = (row_reg == RW1'(COMMIT_ROWS));
    assign sts.row_valid = rowv_reg[row_idx];
    assign sts.row_match = (row_rdata[16:0] == updaddr_reg);
    assign sts.res_last  = last_w;
    assign sts.out_free  = !ovalid_reg || out_ready;

    assign out_valid = ovalid_reg;
    assign out_data  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, od_reg};
    assign out_last  = olast_reg;

    bptb_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_tgt_ram (
        .clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_reg),
        .raddr(ent_idx), .rdata(tgt_rdata)
    );

    bptb_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(ent_idx), .rdata(cnt_rdata)
    );

    bptb_ram #(.WIDTH(19), .DEPTH(TABLE_ENTRIES * PREDS_PER_ENTRY)) u_can_ram (
        .clk(clk), .we(can_we), .waddr(can_waddr), .wdata(can_wdata),
        .raddr(can_raddr), .rdata(can_rdata)
    );

    bptb_ram #(.WIDTH(19), .DEPTH(COMMIT_ROWS)) u_row_ram (
        .clk(clk), .we(row_we), .waddr(RAW'(f_row)), .wdata({f_cpval, f_cpaddr}),
        .raddr(row_idx), .rdata(row_rdata)
    );

    always_comb
    begin
        valid_next    = valid_reg;
        rowv_next     = rowv_reg;
        ctr_next      = ctr_reg;
        delay_next    = delay_reg;
        lat_addr_next = lat_addr_reg;
        lat_val_next  = lat_val_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        rdv_next      = 1'b0;
        br_next       = br_reg;
        key_next      = key_reg;
        tgt_next      = tgt_reg;
        inp_next      = inp_reg;
        inpv_next     = inpv_reg;
        indelay_next  = indelay_reg;
        ent_next      = ent_reg;
        sub_next      = sub_reg;
        row_next      = row_reg;
        rdidx_next    = rdidx_reg;
        kf_next       = kf_reg;
        kidx_next     = kidx_reg;
        kcnt_next     = kcnt_reg;
        tf_next       = tf_reg;
        tidx_next     = tidx_reg;
        tcnt_next     = tcnt_reg;
        ff_next       = ff_reg;
        fidx_next     = fidx_reg;
        rescnt_next   = rescnt_reg;
        outp_next     = outp_reg;
        outcp_next    = outcp_reg;
        full_next     = full_reg;
        updcnt_next   = updcnt_reg;
        updaddr_next  = updaddr_reg;
        od_next       = od_reg;
        olast_next    = olast_reg;
        tgt_we        = 1'b0;
        tgt_waddr     = fidx_reg;
        cnt_we        = 1'b0;
        cnt_waddr     = fidx_reg;
        cnt_wdata     = SW'(1);
        can_we        = 1'b0;
        can_waddr     = slot(fidx_reg, '0);
        can_wdata     = {NONE2, 1'b0, inp_reg};
        row_we        = 1'b0;

        // Tag compare of the entry read in the previous scan cycle.
        if (rdv_reg)
        begin
            if (valid_reg[rdidx_reg] && tgt_rdata == key_reg && !kf_reg)
            begin
                kf_next   = 1'b1;
                kidx_next = rdidx_reg;
                kcnt_next = cnt_rdata;
            end
            if (valid_reg[rdidx_reg] && tgt_rdata == tgt_reg && !tf_reg)
            begin
                tf_next   = 1'b1;
                tidx_next = rdidx_reg;
                tcnt_next = cnt_rdata;
            end
            if (!valid_reg[rdidx_reg] && !ff_reg)
            begin
                ff_next   = 1'b1;
                fidx_next = rdidx_reg;
            end
        end

        case (cmd.op)
            OP_ASSIGN:
            begin
                br_next      = f_br;
                tgt_next     = f_tgt;
                inp_next     = inp_w;
                inpv_next    = ($signed({1'b0, inp_w}) == lat_addr_reg) ?
                               lat_val_reg : NONE2;
                indelay_next = delay_reg & ~f_br;
                key_next     = (delay_reg & ~f_br) ? f_inst - 32'd4 : f_inst;
                ctr_next     = ctr_reg + 16'(delay_reg);
                delay_next   = 1'b0;
                ent_next     = '0;
                kf_next      = 1'b0;
                tf_next      = 1'b0;
                ff_next      = 1'b0;
            end
            OP_COMMIT:
            begin
                if ({28'd0, f_row} < 32'(COMMIT_ROWS))
                begin
                    row_we             = 1'b1;
                    rowv_next[RAW'(f_row)] = 1'b1;
                    if (f_paddr > lat_addr_reg)
                    begin
                        lat_addr_next = f_paddr;
                        lat_val_next  = f_pval;
                    end
                end
            end
            OP_FLUSH:
            begin
                valid_next    = '0;
                ctr_next      = '0;
                delay_next    = 1'b0;
                lat_addr_next = '0;
                lat_val_next  = 2'sd1;
            end
            OP_SCAN:
            begin
                if (ent_reg != EW1'(TABLE_ENTRIES))
                begin
                    rdv_next   = 1'b1;
                    rdidx_next = ent_idx;
                    ent_next   = ent_reg + EW1'(1);
                end
            end
            OP_APPLY:
            begin
                rescnt_next = kf_reg ? kcnt_reg : '0;
                sub_next    = '0;
                full_next   = 1'b0;
                outp_next   = NONE17;
                outcp_next  = NONE17;
                if (kf_reg && !br_reg)
                begin
                    valid_next[kidx_reg] = 1'b0;
                end
                if (!indelay_reg && br_reg)
                begin
                    delay_next = 1'b1;
                    outp_next  = {1'b0, ctr_reg + 16'd1};
                    outcp_next = {1'b0, ctr_reg + 16'd1};
                    can_wdata  = {NONE2, 1'b0, ctr_reg + 16'd1};
                    if (tf_reg)
                    begin
                        if (tcnt_reg < SW'(PREDS_PER_ENTRY))
                        begin
                            can_we    = 1'b1;
                            can_waddr = slot(tidx_reg, tcnt_reg);
                            cnt_we    = 1'b1;
                            cnt_waddr = tidx_reg;
                            cnt_wdata = tcnt_reg + SW'(1);
                        end
                    end
                    else if (ff_reg)
                    begin
                        valid_next[fidx_reg] = 1'b1;
                        tgt_we = 1'b1;
                        cnt_we = 1'b1;
                        can_we = 1'b1;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
                else if (!indelay_reg && kf_reg && kcnt_reg != '0)
                begin
                    ctr_next  = ctr_reg + 16'd1;
                    outp_next = {1'b0, ctr_reg + 16'd1};
                end
            end
            OP_RES_LOAD:
            begin
                ovalid_next = 1'b1;
                olast_next  = last_w;
                od_next     = {full_reg, outcp_reg, outp_reg,
                               (rescnt_reg != '0) ? can_rdata[18:17] : NONE2,
                               (rescnt_reg != '0) ? can_rdata[16:0] : NONE17,
                               3'(rescnt_reg), inpv_reg, inp_reg};
                sub_next    = sub_reg + SW'(1);
            end
            OP_U_INIT:     ent_next = '0;
            OP_U_ENT_NEXT: ent_next = ent_reg + EW1'(1);
            OP_U_CNT_LAT:
            begin
                updcnt_next = cnt_rdata;
                sub_next    = '0;
            end
            OP_U_PRED_LAT:
            begin
                updaddr_next = can_rdata[16:0];
                row_next     = '0;
            end
            OP_U_PRED_NXT: sub_next = sub_reg + SW'(1);
            OP_U_ROW_NEXT: row_next = row_reg + RW1'(1);
            OP_U_MATCH:
            begin
                if (row_rdata[16:0] == updaddr_reg)
                begin
                    can_we    = 1'b1;
                    can_waddr = slot(ent_idx, sub_reg);
                    can_wdata = {row_rdata[18:17], updaddr_reg};
                    sub_next  = sub_reg + SW'(1);
                end
                else
                begin
                    row_next = row_reg + RW1'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rowv_reg     <= '0;
            ctr_reg      <= '0;
            delay_reg    <= 1'b0;
            lat_addr_reg <= '0;
            lat_val_reg  <= 2'sd1;
            ovalid_reg   <= 1'b0;
            rdv_reg      <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rowv_reg     <= rowv_next;
            ctr_reg      <= ctr_next;
            delay_reg    <= delay_next;
            lat_addr_reg <= lat_addr_next;
            lat_val_reg  <= lat_val_next;
            ovalid_reg   <= ovalid_next;
            rdv_reg      <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        br_reg      <= br_next;
        key_reg     <= key_next;
        tgt_reg     <= tgt_next;
        inp_reg     <= inp_next;
        inpv_reg    <= inpv_next;
        indelay_reg <= indelay_next;
        ent_reg     <= ent_next;
        sub_reg     <= sub_next;
        row_reg     <= row_next;
        rdidx_reg   <= rdidx_next;
        kf_reg      <= kf_next;
        kidx_reg    <= kidx_next;
        kcnt_reg    <= kcnt_next;
        tf_reg      <= tf_next;
        tidx_reg    <= tidx_next;
        tcnt_reg    <= tcnt_next;
        ff_reg      <= ff_next;
        fidx_reg    <= fidx_next;
        rescnt_reg  <= rescnt_next;
        outp_reg    <= outp_next;
        outcp_reg   <= outcp_next;
        full_reg    <= full_next;
        updcnt_reg  <= updcnt_next;
        updaddr_reg <= updaddr_next;
        od_reg      <= od_next;
        olast_reg   <= olast_next;
    end

endmodule
